/* rtl/core/sitoda_pkg.sv */
// shared types and constants for the signed integer to decimal ascii block
// no dependencies; used by sitoda_front, sitoda_back and the top level
package sitoda_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CAP_RESET  = 8'd12;

   // response status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_TOO_SMALL = 1'b1;

   // queue status seen by the back end and the request side
   typedef struct packed {
      logic valid;
      logic full;
   } sitoda_q_status_type;

   // one response item
   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       status;
   } sitoda_rsp_type;

   typedef enum logic [2:0] {
      CONV_IDLE  = 3'b001,
      CONV_SHIFT = 3'b010,
      CONV_DONE  = 3'b100
   } sitoda_conv_state_type;

endpackage

/* rtl/core/sitoda_front.sv */
// front end: splits a request into sign and magnitude and queues it
// depends on sitoda_pkg
module sitoda_front #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic signed [VALUE_WIDTH-1:0]     req_value,
   input  logic                              q_take,
   output sitoda_pkg::sitoda_q_status_type   q_status,
   output logic                              q_neg,
   output logic [VALUE_WIDTH-1:0]            q_mag
);

   logic [VALUE_WIDTH:0]   entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   neg;
   logic                   push_ok;
   logic                   take_ok;

   // magnitude of the most negative value wraps to the right unsigned code
   assign raw = VALUE_WIDTH'(req_value);
   assign neg = raw[VALUE_WIDTH-1];
   assign mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.valid = (count_ff != 2'd0);
   assign push_ok = req_push && !q_status.full;
   assign take_ok = q_take && q_status.valid;

   assign {q_neg, q_mag} = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + 2'd1;
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= {neg, mag};
      end
   end

endmodule

/* rtl/core/sitoda_back.sv */
// back end: shift-and-add-3 binary to bcd converter and character emitter
// depends on sitoda_pkg; fed by sitoda_front
module sitoda_back #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sitoda_pkg::sitoda_q_status_type   q_status,
   input  logic                              q_neg,
   input  logic [VALUE_WIDTH-1:0]            q_mag,
   output logic                              q_take,
   input  logic [7:0]                        capacity,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output sitoda_pkg::sitoda_rsp_type        rsp
);

   // digits of the largest magnitude, 2**(VALUE_WIDTH-1)
   localparam int unsigned DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
   localparam int unsigned BCD_W  = 4 * DIGITS;
   localparam int unsigned IDX_W  = $clog2(DIGITS);
   localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);

   sitoda_pkg::sitoda_conv_state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [IDX_W-1:0]       msd;
   logic [7:0]             text_len;
   logic                   too_long;
   logic                   load_emit;

   logic                   hold_ff, hold_in;
   logic [BCD_W-1:0]       e_bcd_ff, e_bcd_in;
   logic                   e_sign_ff, e_sign_in;
   logic [IDX_W-1:0]       e_idx_ff, e_idx_in;
   logic                   e_err_ff, e_err_in;
   logic [3:0]             digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             (bcd_ff[4*i +: 4] + 4'd3) : bcd_ff[4*i +: 4];
      end
   end

   // most significant non-zero digit, zero keeps one digit
   always_comb begin
      msd = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            msd = IDX_W'(i);
         end
      end
   end

   assign text_len = 8'(msd) + 8'(neg_ff) + 8'd1;
   assign too_long = (text_len >= capacity);

   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      q_take    = 1'b0;
      load_emit = 1'b0;
      case (state_ff)
         sitoda_pkg::CONV_IDLE: begin
            if (q_status.valid) begin
               q_take   = 1'b1;
               bin_in   = q_mag;
               bcd_in   = '0;
               neg_in   = q_neg;
               cnt_in   = CNT_W'(VALUE_WIDTH);
               state_in = sitoda_pkg::CONV_SHIFT;
            end
         end
         sitoda_pkg::CONV_SHIFT: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = sitoda_pkg::CONV_DONE;
            end
         end
         sitoda_pkg::CONV_DONE: begin
            if (!hold_ff) begin
               load_emit = 1'b1;
               state_in  = sitoda_pkg::CONV_IDLE;
            end
         end
         default: begin
            state_in = sitoda_pkg::CONV_IDLE;
         end
      endcase
   end

   // emitter walks sign then digits from the most significant down
   always_comb begin
      hold_in   = hold_ff;
      e_bcd_in  = e_bcd_ff;
      e_sign_in = e_sign_ff;
      e_idx_in  = e_idx_ff;
      e_err_in  = e_err_ff;
      if (load_emit) begin
         hold_in   = 1'b1;
         e_bcd_in  = bcd_ff;
         e_sign_in = neg_ff;
         e_idx_in  = msd;
         e_err_in  = too_long;
      end else if (hold_ff && rsp_pop) begin
         if (e_err_ff) begin
            hold_in = 1'b0;
         end else if (e_sign_ff) begin
            e_sign_in = 1'b0;
         end else if (e_idx_ff == '0) begin
            hold_in = 1'b0;
         end else begin
            e_idx_in = e_idx_ff - IDX_W'(1);
         end
      end
   end

   assign digit     = e_bcd_ff[{e_idx_ff, 2'b00} +: 4];
   assign rsp_empty = !hold_ff;

   always_comb begin
      if (e_err_ff) begin
         rsp.character = sitoda_pkg::CHAR_NUL;
         rsp.last      = 1'b1;
         rsp.status    = sitoda_pkg::STATUS_TOO_SMALL;
      end else if (e_sign_ff) begin
         rsp.character = sitoda_pkg::CHAR_MINUS;
         rsp.last      = 1'b0;
         rsp.status    = sitoda_pkg::STATUS_OK;
      end else begin
         rsp.character = sitoda_pkg::CHAR_ZERO + 8'(digit);
         rsp.last      = (e_idx_ff == '0);
         rsp.status    = sitoda_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitoda_pkg::CONV_IDLE;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      e_bcd_ff  <= e_bcd_in;
      e_sign_ff <= e_sign_in;
      e_idx_ff  <= e_idx_in;
      e_err_ff  <= e_err_in;
   end

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// top level of the signed integer to decimal ascii converter
// depends on sitoda_pkg, sitoda_front and sitoda_back
//
//  channel   ports                                     handshake
//  request   req_push req_full req_value               push & !full
//  response  rsp_empty rsp_pop rsp_character/last/st   pop & !empty
//  csr       csr_valid csr_ready csr_buffer_capacity   valid & ready
//
// each request passes through the back end in a load step, one shift-and-add-3
// step per magnitude bit in the converter and a hand-over to the emitter;
// characters then leave one per cycle while rsp_pop is high, while the next value
// converts. a two-entry request queue lets the request side run ahead.
// reset is synchronous and empties the queue, converter and emitter.
// a stalled response side holds the emitter, then the converter, then the queue
module signed_int_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request queue side
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   // response queue side
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_status,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_buffer_capacity
);

   sitoda_pkg::sitoda_q_status_type q_status;
   sitoda_pkg::sitoda_rsp_type      rsp;
   logic                            q_neg;
   logic [VALUE_WIDTH-1:0]          q_mag;
   logic                            q_take;
   logic [7:0]                      capacity_ff, capacity_in;

   // capacity register, always ready
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_buffer_capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= sitoda_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // front end: sign split and request queue
   sitoda_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .q_take    (q_take),
      .q_status  (q_status),
      .q_neg     (q_neg),
      .q_mag     (q_mag)
   );

   assign req_full = q_status.full;

   // back end: conversion and character output
   sitoda_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_neg     (q_neg),
      .q_mag     (q_mag),
      .q_take    (q_take),
      .capacity  (capacity_ff),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_character = rsp.character;
   assign rsp_last      = rsp.last;
   assign rsp_status    = rsp.status;

   // back end only draws from a queue that holds something
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_status.valid)
      else $error("back end took from an empty request queue");

   // in the cycle after reset both queues read empty
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   // an overflow response always closes its run with a nul character
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == sitoda_pkg::STATUS_TOO_SMALL)) |->
      (rsp_last && (rsp_character == sitoda_pkg::CHAR_NUL)))
      else $error("overflow response not a single nul");

endmodule
